// ----- src/cordic_sine_cosine_macros.svh -----
// Assertion macros for the CORDIC sine/cosine block.
`ifndef CORDIC_SINE_COSINE_MACROS_SVH
`define CORDIC_SINE_COSINE_MACROS_SVH
// Assert that a property holds each cycle out of reset.
`define CSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition implies a property on the next cycle.
`define CSC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

// ----- src/csc_pkg.sv -----
// Shared constants, tables and functions for the CORDIC sine/cosine block.
package csc_pkg;
	localparam int ITERATIONS_DEF = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int OUT_FRAC_BITS_DEF = 16;
	localparam int ANGLE_W = 32;
	localparam int RESID_FRAC = 32;
	localparam int VEC_FRAC = 30;
	localparam int GAIN_FRAC = 32;
	localparam int Z_W = 44;
	localparam int V_W = 34;
	localparam int K_W = 25;
	localparam int QDEPTH = 4;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] red;
		logic                      neg;
	} csc_item_t;

	function automatic logic signed [Z_W-1:0] atan_deg(input int i);
		logic signed [39:0] t;
		begin
			case (i)
				0: t = 40'sd193273528320; 1: t = 40'sd114096026022;
				2: t = 40'sd60285206653; 3: t = 40'sd30601712202;
				4: t = 40'sd15360239180; 5: t = 40'sd7687607525;
				6: t = 40'sd3844741810; 7: t = 40'sd1922488225;
				8: t = 40'sd961258780; 9: t = 40'sd480631223;
				10: t = 40'sd240315841; 11: t = 40'sd120157949;
				12: t = 40'sd60078978; 13: t = 40'sd30039489;
				14: t = 40'sd15019745; 15: t = 40'sd7509872;
				16: t = 40'sd3754936; 17: t = 40'sd1877468;
				18: t = 40'sd938734; 19: t = 40'sd469367;
				20: t = 40'sd234684; 21: t = 40'sd117342;
				22: t = 40'sd58671; 23: t = 40'sd29335;
				24: t = 40'sd14668; 25: t = 40'sd7334;
				26: t = 40'sd3667; 27: t = 40'sd1833;
				28: t = 40'sd917; 29: t = 40'sd458;
				30: t = 40'sd229; default: t = 40'sd115;
			endcase
			atan_deg = Z_W'(t);
		end
	endfunction

	function automatic logic [32:0] gain_of(input int n);
		begin
			case (n)
				8: gain_of = 33'd2608158028; 9: gain_of = 33'd2608138129;
				10: gain_of = 33'd2608133154; 11: gain_of = 33'd2608131911;
				12: gain_of = 33'd2608131600; 13: gain_of = 33'd2608131522;
				14: gain_of = 33'd2608131503; 15: gain_of = 33'd2608131498;
				16: gain_of = 33'd2608131497; default: gain_of = 33'd2608131496;
			endcase
		end
	endfunction
endpackage

// ----- src/csc_if.sv -----
// Valid/ready channel interface.
interface csc_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/csc_front.sv -----
// Front: range reduction by division by 180 (reciprocal multiply), pipelined.
module csc_front #(
	parameter int ANGLE_FRAC_BITS = csc_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [csc_pkg::ANGLE_W-1:0] angle,
	output logic                            out_valid,
	output csc_pkg::csc_item_t              item
);
	import csc_pkg::*;
	localparam longint HALF = 64'sd90 <<< ANGLE_FRAC_BITS;
	localparam longint TURN = 64'sd180 <<< ANGLE_FRAC_BITS;
	// half turn is 180 << ANGLE_FRAC_BITS, so divide the shifted numerator by 180
	localparam int SH = 32;
	localparam longint RECIP = ((64'sd1 <<< SH) + 180 - 1) / 180;
	logic                   v_s1, v_s2, v_s3;
	logic signed [33:0]     num_s1;
	logic                   pos_s1, pos_s2;
	logic signed [ANGLE_W-1:0] a_s1, a_s2, a_s3;
	logic [63:0]            prod_s2;
	logic [K_W-1:0]         k_c;
	logic signed [63:0]     adj_c;
	logic                   neg_s3;
	logic signed [33:0]     numc;
	logic                   pc, nc;

	always_comb begin
		pc = 64'(angle) > HALF;
		nc = 64'(angle) < -HALF;
		if (pc) numc = 34'(64'(angle) - HALF + TURN - 1);
		else if (nc) numc = 34'(-HALF - 64'(angle) + TURN - 1);
		else numc = '0;
		k_c = K_W'(prod_s2 >> SH);
		adj_c = 64'(a_s2) + (pos_s2 ? -64'(k_c) * TURN : 64'(k_c) * TURN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= numc; pos_s1 <= pc; a_s1 <= angle;
			prod_s2 <= 64'(num_s1[32:0] >> ANGLE_FRAC_BITS) * 64'(RECIP);
			pos_s2 <= pos_s1; a_s2 <= a_s1;
			a_s3 <= ANGLE_W'(adj_c);
			neg_s3 <= k_c[0];
		end
	end

	assign out_valid = v_s3 & en;
	assign item.red = a_s3;
	assign item.neg = neg_s3;
endmodule

// ----- src/csc_fifo.sv -----
// Short queue between front and back.
module csc_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csc_pkg::csc_item_t wdata,
	input  logic               pop,
	output csc_pkg::csc_item_t rdata,
	output logic               nonempty,
	output logic [2:0]         count
);
	import csc_pkg::*;
	csc_item_t mem_q [QDEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign nonempty = cnt_q != 3'd0;
	assign count = cnt_q;
endmodule

// ----- src/csc_back.sv -----
// Back: unrolled CORDIC pipeline, gain multiply, rounding and saturation.
`include "cordic_sine_cosine_macros.svh"
module csc_back #(
	parameter int ITERATIONS = csc_pkg::ITERATIONS_DEF,
	parameter int ANGLE_FRAC_BITS = csc_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = csc_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  csc_pkg::csc_item_t          item,
	output logic                        out_valid,
	output logic signed [OUT_FRAC_BITS+1:0] sine,
	output logic signed [OUT_FRAC_BITS+1:0] cosine
);
	import csc_pkg::*;
	localparam int N = (ITERATIONS < 8) ? 8 : ((ITERATIONS > 32) ? 32 : ITERATIONS);
	localparam int OW = OUT_FRAC_BITS + 2;
	localparam int SH = VEC_FRAC + GAIN_FRAC - OUT_FRAC_BITS;
	localparam int P_W = V_W + 34;
	localparam logic [32:0] GAIN = gain_of(N);
	localparam logic signed [OW-1:0] UNIT = OW'(1) <<< OUT_FRAC_BITS;
	logic                    v_q [N+3];
	logic signed [Z_W-1:0]   z_q [N+1];
	logic signed [V_W-1:0]   x_q [N+1];
	logic signed [V_W-1:0]   y_q [N+1];
	logic                    n_q [N+2];
	logic signed [P_W-1:0]   px_q, py_q;
	logic signed [OW-1:0]    c_q, s_q;

	function automatic logic signed [OW-1:0] sat(input logic signed [P_W-1:0] p);
		logic signed [P_W-1:0] r;
		begin
			r = (p + (P_W'(1) <<< (SH - 1))) >>> SH;
			if (r > (P_W'(1) <<< OUT_FRAC_BITS)) sat = OW'(1) <<< OUT_FRAC_BITS;
			else if (r < -(P_W'(1) <<< OUT_FRAC_BITS)) sat = -(OW'(1) <<< OUT_FRAC_BITS);
			else sat = OW'(r);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < N + 3; j++) v_q[j] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int j = 1; j < N + 3; j++) v_q[j] <= v_q[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_q[0] <= Z_W'(item.red) <<< (RESID_FRAC - ANGLE_FRAC_BITS);
			x_q[0] <= V_W'(1) <<< VEC_FRAC;
			y_q[0] <= '0;
			n_q[0] <= item.neg;
			for (int i = 0; i < N; i++) begin
				n_q[i+1] <= n_q[i];
				if (z_q[i][Z_W-1]) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_deg(i);
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_deg(i);
				end
			end
			px_q <= P_W'(x_q[N]) * P_W'($signed({1'b0, GAIN}));
			py_q <= P_W'(y_q[N]) * P_W'($signed({1'b0, GAIN}));
			n_q[N+1] <= n_q[N];
			c_q <= n_q[N+1] ? -sat(px_q) : sat(px_q);
			s_q <= n_q[N+1] ? -sat(py_q) : sat(py_q);
		end
	end

	assign out_valid = v_q[N+2];
	assign sine = s_q;
	assign cosine = c_q;

	`CSC_ASSERT(a_sat_c, clk, arst_n, !out_valid || (cosine <= UNIT && cosine >= -UNIT), "cosine out of range")
	`CSC_ASSERT(a_sat_s, clk, arst_n, !out_valid || (sine <= UNIT && sine >= -UNIT), "sine out of range")
	`CSC_ASSERT_NEXT(a_hold, clk, arst_n, !en, $stable(out_valid), "stall changed valid")
endmodule

// ----- src/cordic_sine_cosine.sv -----
// Top level of the CORDIC sine/cosine generator.
// channel | dir | payload
// in      | in  | angle_deg [31:0] signed, degrees Q.ANGLE_FRAC_BITS
// out     | out | sine_value, cosine_value [OUT_FRAC_BITS+1:0] signed Q1
// One beat per cycle sustained while the output channel is ready; an angle taken in
// passes the 3 reduction stages, the queue, the back pipeline and the output register.
// Front and back are unrolled pipelines; a 4-entry queue decouples them.
// Back stalls as a whole while the output register holds a beat not yet taken.
// Front stalls only while the queue is full. Reset clears valids and queue pointers and count only.
`include "cordic_sine_cosine_macros.svh"
module cordic_sine_cosine #(
	parameter int ITERATIONS = csc_pkg::ITERATIONS_DEF,
	parameter int ANGLE_FRAC_BITS = csc_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = csc_pkg::OUT_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	csc_if.sink   in_ch,
	csc_if.source out_ch
);
	import csc_pkg::*;
	localparam int OW = OUT_FRAC_BITS + 2;
	logic      f_en, f_v, b_en, b_v, pop, ne;
	csc_item_t f_item, q_item;
	logic [2:0] cnt;
	logic signed [OW-1:0] s_w, c_w;
	logic      ov_q;
	logic [2*OW-1:0] od_q;

	// front stalls as a whole once the queue is full
	assign f_en = cnt != 3'(QDEPTH);
	assign in_ch.ready = f_en;
	assign b_en = !ov_q || out_ch.ready;
	assign pop = ne && b_en;

	csc_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
		.clk, .arst_n, .en(f_en), .in_valid(in_ch.valid), .angle(in_ch.data[ANGLE_W-1:0]),
		.out_valid(f_v), .item(f_item));

	csc_fifo u_fifo (.clk, .arst_n, .push(f_v), .wdata(f_item), .pop,
		.rdata(q_item), .nonempty(ne), .count(cnt));

	csc_back #(.ITERATIONS(ITERATIONS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
		.clk, .arst_n, .en(b_en), .in_valid(pop), .item(q_item),
		.out_valid(b_v), .sine(s_w), .cosine(c_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (b_en) begin
			ov_q <= b_v;
		end
	end

	always_ff @(posedge clk) begin
		if (b_en) od_q <= {s_w, c_w};
	end

	assign out_ch.valid = ov_q;
	assign out_ch.data = od_q;

	`CSC_ASSERT(a_noovf, clk, arst_n, !(f_v && cnt == 3'(QDEPTH)), "queue overflow")
endmodule
